@@ design/ctp_pkg.sv @@
// Shared constants, types and elaboration-time tables for the CORDIC Cartesian-to-polar core.
package ctp_pkg;

	localparam int DATA_WIDTH  = 32;
	localparam int INT_BITS    = 9;
	localparam int FRAC_BITS   = DATA_WIDTH - INT_BITS;
	localparam int COORD_WIDTH = 32;
	localparam int MAG_WIDTH   = 32;
	localparam int ANGLE_WIDTH = 26;
	localparam int K_WIDTH     = 32;
	localparam int TABLE_LEN   = 22;

	localparam logic [63:0] DEC_ONE = 64'd1000000000000;

	localparam logic [K_WIDTH-1:0] K_MAG = 32'd2608131496;
	localparam logic [K_WIDTH-1:0] K_RAD = 32'd74961353;

	localparam logic [DATA_WIDTH-1:0] C180 = DATA_WIDTH'(64'd180 << FRAC_BITS);

	// atan(2^-i) in units of 1e-12 degree
	localparam logic [63:0] ATAN_DEG_PICO [TABLE_LEN] = '{
		64'd45000000000000, 64'd26565051180000, 64'd14036243470000, 64'd7125016349000,
		64'd3576334375000,  64'd1789910608000,  64'd895173710200,   64'd447614170900,
		64'd223810500400,   64'd111905677100,   64'd55952891890,    64'd27976452620,
		64'd13988227140,    64'd6994113675,     64'd3497056851,     64'd1748528427,
		64'd874264214,      64'd437132107,      64'd218566053,      64'd109283027,
		64'd54641513,       64'd27320757
	};

	typedef enum logic [1:0] {
		CORR_NONE,
		CORR_NEG,
		CORR_POS
	} ctp_corr_t;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] x;
		logic [DATA_WIDTH-1:0] y;
		logic [DATA_WIDTH-1:0] th;
		ctp_corr_t             corr;
		logic                  ovf;
	} ctp_data_t;

	// degree table entry rounded half up to FRAC_BITS fraction bits; evaluated at elaboration
	function automatic logic [63:0] phase_q(input int idx);
		logic [63:0] d;
		logic [63:0] val;
		logic [63:0] rem;
		if (idx < 0 || idx >= TABLE_LEN) begin
			return 64'd0;
		end
		d   = ATAN_DEG_PICO[idx];
		val = d / DEC_ONE;
		rem = d % DEC_ONE;
		for (int k = 0; k < FRAC_BITS; k++) begin
			rem = rem << 1;
			val = val << 1;
			if (rem >= DEC_ONE) begin
				val = val | 64'd1;
				rem = rem - DEC_ONE;
			end
		end
		if ((rem << 1) >= DEC_ONE) begin
			val = val + 64'd1;
		end
		return val;
	endfunction

endpackage

@@ design/ctp_in_if.sv @@
// Input channel: Cartesian point transfer.
interface ctp_in_if
	import ctp_pkg::*;
;
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] x_coord;
	logic signed [COORD_WIDTH-1:0] y_coord;

	modport source (output valid, x_coord, y_coord, input ready);
	modport sink (input valid, x_coord, y_coord, output ready);
endinterface

@@ design/ctp_out_if.sv @@
// Output channel: polar result transfer.
interface ctp_out_if
	import ctp_pkg::*;
;
	logic                          valid;
	logic                          ready;
	logic signed [MAG_WIDTH-1:0]   magnitude;
	logic signed [ANGLE_WIDTH-1:0] angle_rad;
	logic                          overflow;

	modport source (output valid, magnitude, angle_rad, overflow, input ready);
	modport sink (input valid, magnitude, angle_rad, overflow, output ready);
endinterface

@@ design/ctp_cell.sv @@
// One vectoring CORDIC cell: fixed shift, fixed arctangent step, one register stage.
module ctp_cell
	import ctp_pkg::*;
#(
	parameter int SHIFT = 0
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      up_valid,
	output logic      up_ready,
	input  ctp_data_t up_data,
	output logic      dn_valid,
	input  logic      dn_ready,
	output ctp_data_t dn_data
);

	localparam int W = DATA_WIDTH + 2;
	localparam logic signed [W-1:0] HALF = (W'(1) << SHIFT) >>> 1;
	localparam logic [63:0] PH_FULL = phase_q(SHIFT);
	localparam logic [DATA_WIDTH-1:0] PH = PH_FULL[DATA_WIDTH-1:0];
	localparam logic PH_OVF = (PH_FULL >> (DATA_WIDTH - 1)) != 64'd0;
	localparam bit IN_FRAC = SHIFT <= FRAC_BITS;

	logic                    neg;
	logic signed [W-1:0]     xe, ye, ax, ay, tx, ty, sx, sy;
	logic signed [DATA_WIDTH:0] the, phe, ts;
	ctp_data_t               nxt;
	logic                    valid_q;
	ctp_data_t               data_q;

	always_comb begin
		neg = up_data.y[DATA_WIDTH-1];
		xe  = {{2{up_data.x[DATA_WIDTH-1]}}, up_data.x};
		ye  = {{2{up_data.y[DATA_WIDTH-1]}}, up_data.y};
		ay  = neg ? -ye : ye;
		ax  = neg ? xe : -xe;
		if (IN_FRAC) begin
			tx = (ay + HALF) >>> SHIFT;
			ty = (ax + HALF) >>> SHIFT;
		end else begin
			tx = '0;
			ty = '0;
		end
		sx  = xe + tx;
		sy  = ye + ty;
		the = {up_data.th[DATA_WIDTH-1], up_data.th};
		phe = {PH[DATA_WIDTH-1], PH};
		ts  = neg ? the - phe : the + phe;

		nxt.x    = sx[DATA_WIDTH-1:0];
		nxt.y    = sy[DATA_WIDTH-1:0];
		nxt.th   = ts[DATA_WIDTH-1:0];
		nxt.corr = up_data.corr;
		nxt.ovf  = up_data.ovf | PH_OVF
			| (sx[W-1:DATA_WIDTH-1] != {3{sx[DATA_WIDTH-1]}})
			| (sy[W-1:DATA_WIDTH-1] != {3{sy[DATA_WIDTH-1]}})
			| (ts[DATA_WIDTH] != ts[DATA_WIDTH-1]);
	end

	assign up_ready = !valid_q || dn_ready;
	assign dn_valid = valid_q;
	assign dn_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			data_q <= nxt;
		end
	end

endmodule

@@ design/ctp_scale.sv @@
// Quadrant correction, gain and degree-to-radian scaling, output register.
module ctp_scale
	import ctp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      up_valid,
	output logic      up_ready,
	input  ctp_data_t up_data,
	ctp_out_if.source polar
);

	localparam int PROD_W = DATA_WIDTH + K_WIDTH;
	localparam logic [K_WIDTH-1:0] RHALF = {1'b1, {(K_WIDTH-1){1'b0}}};

	function automatic logic signed [DATA_WIDTH+1:0] round_prod(
		input logic [PROD_W-1:0] p,
		input logic              neg
	);
		logic [DATA_WIDTH-1:0] q;
		logic [K_WIDTH-1:0]    r;
		logic                  inc;
		logic [DATA_WIDTH:0]   qq;
		q   = p[PROD_W-1:K_WIDTH];
		r   = p[K_WIDTH-1:0];
		inc = neg ? (r > RHALF) : (r >= RHALF);
		qq  = {1'b0, q} + (DATA_WIDTH+1)'(inc);
		return neg ? -$signed({1'b0, qq}) : $signed({1'b0, qq});
	endfunction

	// stage 1: +-180 degree correction
	logic                          v_s1, rdy_s1;
	logic [DATA_WIDTH-1:0]         x_s1, th_s1;
	logic                          ovf_s1;
	logic signed [DATA_WIDTH+1:0]  the, c180e, tc;

	// stage 2: products
	logic                          v_s2, rdy_s2;
	logic [PROD_W-1:0]             pm_s2, pr_s2;
	logic                          nm_s2, nr_s2, ovf_s2;
	logic [DATA_WIDTH-1:0]         mx, mt;

	// stage 3: rounded results
	logic                          v_s3, rdy_s3;
	logic [MAG_WIDTH-1:0]          mag_s3;
	logic [ANGLE_WIDTH-1:0]        ang_s3;
	logic                          ovf_s3;
	logic signed [DATA_WIDTH+1:0]  rm, rr;
	logic                          ovf_out;

	assign rdy_s3   = !v_s3 || polar.ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	always_comb begin
		the   = {{2{up_data.th[DATA_WIDTH-1]}}, up_data.th};
		c180e = {2'b00, C180};
		case (up_data.corr)
			CORR_NEG: tc = -c180e - the;
			CORR_POS: tc = c180e - the;
			default:  tc = the;
		endcase
	end

	always_comb begin
		mx = x_s1[DATA_WIDTH-1] ? -x_s1 : x_s1;
		mt = th_s1[DATA_WIDTH-1] ? -th_s1 : th_s1;
	end

	always_comb begin
		rm      = round_prod(pm_s2, nm_s2);
		rr      = round_prod(pr_s2, nr_s2);
		ovf_out = ovf_s2
			| ($signed(rm) != $signed(rm[MAG_WIDTH-1:0]))
			| ($signed(rr) != $signed(rr[ANGLE_WIDTH-1:0]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= up_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && rdy_s1) begin
			x_s1   <= up_data.x;
			th_s1  <= tc[DATA_WIDTH-1:0];
			ovf_s1 <= up_data.ovf | (tc[DATA_WIDTH+1:DATA_WIDTH-1] != {3{tc[DATA_WIDTH-1]}});
		end
		if (v_s1 && rdy_s2) begin
			pm_s2  <= PROD_W'(mx) * PROD_W'(K_MAG);
			pr_s2  <= PROD_W'(mt) * PROD_W'(K_RAD);
			nm_s2  <= x_s1[DATA_WIDTH-1];
			nr_s2  <= th_s1[DATA_WIDTH-1];
			ovf_s2 <= ovf_s1;
		end
		if (v_s2 && rdy_s3) begin
			mag_s3 <= rm[MAG_WIDTH-1:0];
			ang_s3 <= rr[ANGLE_WIDTH-1:0];
			ovf_s3 <= ovf_out;
		end
	end

	assign polar.valid     = v_s3;
	assign polar.magnitude = mag_s3;
	assign polar.angle_rad = ang_s3;
	assign polar.overflow  = ovf_s3;

endmodule

@@ design/cordic_cartesian_to_polar_core.sv @@
// Top level: CORDIC vectoring core, signed Q9.23 point to magnitude and angle in radians.
// Accepts one point per clock while the output is taking results and returns one result
// per point, in order. Each point passes one register per CORDIC cell, then the correction,
// multiply and rounding stages. Each stage holds one item and takes a new one whenever
// it is empty or moving on, so a result waiting at the output does not block upstream
// stages that still have room.
module cordic_cartesian_to_polar_core
	import ctp_pkg::*;
#(
	parameter int ITERATIONS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	ctp_in_if.sink   point,
	ctp_out_if.source polar
);

	logic [ITERATIONS:0] vld;
	logic [ITERATIONS:0] rdy;
	ctp_data_t           dat [ITERATIONS+1];
	ctp_data_t           din;

	logic [DATA_WIDTH-1:0] xin, yin;
	logic [DATA_WIDTH:0]   xneg;
	logic                  xsign;

	always_comb begin
		xin   = DATA_WIDTH'(point.x_coord);
		yin   = DATA_WIDTH'(point.y_coord);
		xsign = xin[DATA_WIDTH-1];
		xneg  = -{xin[DATA_WIDTH-1], xin};

		din.y   = yin;
		din.th  = '0;
		if (xsign) begin
			din.x    = xneg[DATA_WIDTH-1:0];
			din.corr = yin[DATA_WIDTH-1] ? CORR_NEG : CORR_POS;
			din.ovf  = xneg[DATA_WIDTH] != xneg[DATA_WIDTH-1];
		end else begin
			din.x    = xin;
			din.corr = CORR_NONE;
			din.ovf  = 1'b0;
		end
	end

	assign dat[0]      = din;
	assign vld[0]      = point.valid;
	assign point.ready = rdy[0];

	for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
		ctp_cell #(
			.SHIFT(i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.up_valid(vld[i]),
			.up_ready(rdy[i]),
			.up_data (dat[i]),
			.dn_valid(vld[i+1]),
			.dn_ready(rdy[i+1]),
			.dn_data (dat[i+1])
		);
	end

	ctp_scale u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.up_valid(vld[ITERATIONS]),
		.up_ready(rdy[ITERATIONS]),
		.up_data (dat[ITERATIONS]),
		.polar   (polar)
	);

endmodule

@@ bench/cordic_cartesian_to_polar_core_tb.sv @@
// Self-checking testbench for the CORDIC Cartesian-to-polar core with a bit-exact predictor.
`timescale 1ns / 100ps

module cordic_cartesian_to_polar_core_tb
	import ctp_pkg::*;
;

	localparam int CORDIC_STEPS = 16;
	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_CYCLES = 40;
	localparam longint C180_Q = 64'd1509949440;
	localparam logic [31:0] MAG_GAIN_Q32 = 32'd2608131496;
	localparam logic [31:0] DEG_TO_RAD_Q32 = 32'd74961353;
	localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] Q_ONE = 32'sh0080_0000;

	// atan(2^-i) in 1e-12 degree
	localparam logic [63:0] ATAN_PDEG [16] = '{
		64'd45000000000000, 64'd26565051180000, 64'd14036243470000, 64'd7125016349000,
		64'd3576334375000, 64'd1789910608000, 64'd895173710200, 64'd447614170900,
		64'd223810500400, 64'd111905677100, 64'd55952891890, 64'd27976452620,
		64'd13988227140, 64'd6994113675, 64'd3497056851, 64'd1748528427
	};

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] mag;
		logic signed [25:0] ang;
		logic               ovf;
	} polar_t;

	logic clk;
	logic arst_n;

	ctp_in_if  pt_ch ();
	ctp_out_if pol_ch ();

	cordic_cartesian_to_polar_core #(
		.ITERATIONS(CORDIC_STEPS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.point(pt_ch),
		.polar(pol_ch)
	);

	polar_t pending_polar [$];
	int mismatch_count = 0;
	int cycle_count = 0;
	int hold_cycles = 0;
	bit idling = 1'b1;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic longint wrap32(input longint v, inout bit ovf);
		logic signed [31:0] w;
		w = v[31:0];
		if (longint'(w) != v) ovf = 1'b1;
		return longint'(w);
	endfunction

	function automatic longint atan_step_q(input int i);
		logic [127:0] p;
		if (i >= 16) return 0;
		p = 128'(ATAN_PDEG[i]) * 128'd8388608 + 128'd500000000000;
		return longint'(p / 128'd1000000000000);
	endfunction

	// round half up of v * k / 2^32
	function automatic longint scale_q32(input longint v, input logic [31:0] k);
		logic signed [65:0] p;
		p = v;
		p = p * $signed({34'd0, k});
		p = p + 66'sd2147483648;
		p = p >>> 32;
		return longint'(p);
	endfunction

	function automatic polar_t predict_polar(input logic signed [31:0] xin,
			input logic signed [31:0] yin);
		polar_t r;
		longint x, y, th, tx, ty, ph, rnd, mag, rad;
		bit ovf, neg;
		ctp_corr_t fold;
		x = xin;
		y = yin;
		th = 0;
		ovf = 1'b0;
		fold = CORR_NONE;
		if (x < 0) begin
			x = wrap32(-x, ovf);
			fold = (y < 0) ? CORR_NEG : CORR_POS;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			neg = (y < 0);
			rnd = (i > 0) ? (longint'(1) << (i - 1)) : 0;
			tx = ((neg ? -y : y) + rnd) >>> i;
			ty = ((neg ? x : -x) + rnd) >>> i;
			ph = atan_step_q(i);
			x = wrap32(x + tx, ovf);
			y = wrap32(y + ty, ovf);
			th = wrap32(neg ? th - ph : th + ph, ovf);
		end
		case (fold)
			CORR_NEG: th = wrap32(-C180_Q - th, ovf);
			CORR_POS: th = wrap32(C180_Q - th, ovf);
			default: ;
		endcase
		mag = scale_q32(x, MAG_GAIN_Q32);
		rad = scale_q32(th, DEG_TO_RAD_Q32);
		if (mag < -longint'(64'd2147483648) || mag > longint'(64'd2147483647)) ovf = 1'b1;
		if (rad < -(longint'(1) << 25) || rad >= (longint'(1) << 25)) ovf = 1'b1;
		r.x = xin;
		r.y = yin;
		r.mag = mag[31:0];
		r.ang = rad[25:0];
		r.ovf = ovf;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("MISMATCH: %0s", msg);
	endtask

	task automatic send_point(input logic signed [31:0] xv, input logic signed [31:0] yv);
		int gap;
		if (idling && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 18);
			pt_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pt_ch.valid <= 1'b1;
		pt_ch.x_coord <= xv;
		pt_ch.y_coord <= yv;
		@(posedge clk);
		while (!pt_ch.ready) @(posedge clk);
		pending_polar.push_back(predict_polar(xv, yv));
	endtask

	// sender stops until every expected result is back
	task automatic settle();
		pt_ch.valid <= 1'b0;
		while (pending_polar.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_coord(input int kind);
		logic signed [31:0] v;
		case (kind)
			0: v = $urandom;
			1: v = $urandom_range(0, 131071) - 65536;
			2: v = $urandom_range(0, 1 << 26) - (1 << 25);
			3: begin
				case ($urandom_range(0, 5))
					0: v = 0;
					1: v = COORD_MAX;
					2: v = COORD_MIN;
					3: v = 1;
					4: v = -1;
					default: v = $urandom;
				endcase
			end
			default: v = {$urandom_range(0, 1) ? 2'b01 : 2'b10, 30'($urandom)};
		endcase
		return v;
	endfunction

	task automatic test_directed();
		send_point(0, 0);
		send_point(COORD_MAX, 0);
		send_point(COORD_MIN, 0);
		send_point(0, COORD_MAX);
		send_point(0, COORD_MIN);
		send_point(COORD_MAX, COORD_MAX);
		send_point(COORD_MIN, COORD_MIN);
		send_point(COORD_MAX, COORD_MIN);
		send_point(COORD_MIN, COORD_MAX);
		send_point(COORD_MIN, 1);
		send_point(COORD_MIN, -1);
		send_point(-1, 0);
		send_point(-1, -1);
		send_point(1, -1);
		send_point(-5, 0);
		send_point(Q_ONE, Q_ONE);
		send_point(-Q_ONE, Q_ONE);
		send_point(-Q_ONE, -Q_ONE);
		send_point(Q_ONE, -Q_ONE);
		send_point(32'sh4000_0000, 32'sh4000_0000);
		send_point(32'sh7000_0000, 32'sh6000_0000);
		send_point(-32'sh7000_0000, 32'sh0000_1000);
		send_point(-32'sh7000_0000, -32'sh0000_1000);
	endtask

	task automatic test_random(input int count);
		int kind;
		for (int n = 0; n < count; n++) begin
			kind = $urandom_range(0, 5);
			if (kind == 5)
				send_point(-$signed(32'($urandom_range(1, 32'h7FFF_FFFF))), rand_coord(0));
			else
				send_point(rand_coord(kind), rand_coord($urandom_range(0, 5)));
		end
	endtask

	// output held off long enough that the pipe fills and input stalls
	task automatic test_backpressure();
		idling = 1'b0;
		hold_cycles = 160;
		for (int n = 0; n < 48; n++)
			send_point(rand_coord($urandom_range(0, 5)), rand_coord($urandom_range(0, 5)));
		idling = 1'b1;
	endtask

	task automatic test_streaming(input int count);
		idling = 1'b0;
		for (int n = 0; n < count; n++)
			send_point(rand_coord($urandom_range(0, 5)), rand_coord($urandom_range(0, 5)));
	endtask

	initial begin
		arst_n <= 1'b0;
		pt_ch.valid <= 1'b0;
		pt_ch.x_coord <= '0;
		pt_ch.y_coord <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		settle();
		test_random(930);
		settle();
		test_backpressure();
		settle();
		test_streaming(250);
		settle();
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		int rx_idle_left;
		rx_idle_left = 0;
		pol_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				pol_ch.ready <= 1'b0;
				hold_cycles--;
			end else if (rx_idle_left > 0) begin
				pol_ch.ready <= 1'b0;
				rx_idle_left--;
			end else if (idling && $urandom_range(0, 7) == 0) begin
				rx_idle_left = $urandom_range(1, 18) - 1;
				pol_ch.ready <= 1'b0;
			end else begin
				pol_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		polar_t exp_r;
		if (arst_n && pol_ch.valid && pol_ch.ready) begin
			if (pending_polar.size() == 0) begin
				report_mismatch($sformatf("unexpected transfer mag=%0d ang=%0d ovf=%0b",
					pol_ch.magnitude, pol_ch.angle_rad, pol_ch.overflow));
			end else begin
				exp_r = pending_polar.pop_front();
				if (pol_ch.magnitude !== exp_r.mag)
					report_mismatch($sformatf("x=%0d y=%0d magnitude %0d, expected %0d",
						exp_r.x, exp_r.y, pol_ch.magnitude, exp_r.mag));
				if (pol_ch.angle_rad !== exp_r.ang)
					report_mismatch($sformatf("x=%0d y=%0d angle_rad %0d, expected %0d",
						exp_r.x, exp_r.y, pol_ch.angle_rad, exp_r.ang));
				if (pol_ch.overflow !== exp_r.ovf)
					report_mismatch($sformatf("x=%0d y=%0d overflow %0b, expected %0b",
						exp_r.x, exp_r.y, pol_ch.overflow, exp_r.ovf));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

endmodule

@@ sim.f @@
design/ctp_pkg.sv
design/ctp_in_if.sv
design/ctp_out_if.sv
design/ctp_cell.sv
design/ctp_scale.sv
design/cordic_cartesian_to_polar_core.sv
bench/cordic_cartesian_to_polar_core_tb.sv
